// ===== design/sgi_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package sgi_pkg;

    localparam int ROWS_DEF        = 25;
    localparam int COLS_DEF        = 80;
    localparam int STACK_DEPTH_DEF = 256;
    localparam int DATA_W          = 32;
    localparam int CHAR_W          = 8;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_STEP = 1'b1;

    localparam logic [7:0] CH_SPACE   = 8'h20;
    localparam logic [7:0] CH_NOT     = 8'h21;
    localparam logic [7:0] CH_QUOTE   = 8'h22;
    localparam logic [7:0] CH_BRIDGE  = 8'h23;
    localparam logic [7:0] CH_DROP    = 8'h24;
    localparam logic [7:0] CH_MOD     = 8'h25;
    localparam logic [7:0] CH_INNUM   = 8'h26;
    localparam logic [7:0] CH_MUL     = 8'h2A;
    localparam logic [7:0] CH_ADD     = 8'h2B;
    localparam logic [7:0] CH_OUTCHR  = 8'h2C;
    localparam logic [7:0] CH_SUB     = 8'h2D;
    localparam logic [7:0] CH_OUTNUM  = 8'h2E;
    localparam logic [7:0] CH_DIV     = 8'h2F;
    localparam logic [7:0] CH_ZERO    = 8'h30;
    localparam logic [7:0] CH_NINE    = 8'h39;
    localparam logic [7:0] CH_DUP     = 8'h3A;
    localparam logic [7:0] CH_LEFT    = 8'h3C;
    localparam logic [7:0] CH_RIGHT   = 8'h3E;
    localparam logic [7:0] CH_HALT    = 8'h40;
    localparam logic [7:0] CH_SWAP    = 8'h5C;
    localparam logic [7:0] CH_UP      = 8'h5E;
    localparam logic [7:0] CH_HBRANCH = 8'h5F;
    localparam logic [7:0] CH_GREATER = 8'h60;
    localparam logic [7:0] CH_GET     = 8'h67;
    localparam logic [7:0] CH_PUT     = 8'h70;
    localparam logic [7:0] CH_DOWN    = 8'h76;
    localparam logic [7:0] CH_VBRANCH = 8'h7C;
    localparam logic [7:0] CH_INCHR   = 8'h7E;

    typedef enum logic [1:0] {
        HEAD_RIGHT = 2'd0,
        HEAD_DOWN  = 2'd1,
        HEAD_LEFT  = 2'd2,
        HEAD_UP    = 2'd3
    } heading_t;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_FETCH,
        ST_POP,
        ST_POP_WAIT,
        ST_EXEC,
        ST_DIV,
        ST_DIV_FIX,
        ST_GET_WAIT,
        ST_PUSH,
        ST_MOVE
    } state_t;

    // Number of stack operands an instruction consumes.
    function automatic logic [1:0] pop_count(input logic [7:0] c);
        logic [1:0] n;
        begin
            case (c)
                CH_HBRANCH, CH_VBRANCH, CH_OUTNUM, CH_OUTCHR,
                CH_DROP, CH_NOT, CH_DUP:                        n = 2'd1;
                CH_ADD, CH_SUB, CH_MUL, CH_DIV, CH_MOD,
                CH_GREATER, CH_SWAP, CH_GET:                    n = 2'd2;
                CH_PUT:                                         n = 2'd3;
                default:                                        n = 2'd0;
            endcase
            return n;
        end
    endfunction

endpackage

`default_nettype wire

// ===== design/sgi_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none

module sgi_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ===== design/stack_grid_interpreter_step_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Channel  Dir  Beat contents (lowest bit first)
// s_*      in   tuser: command; tdata: cell_row, cell_col, cell_char, input_value
// m_*      out  tuser: out_is_char; tdata: out_valid, out_value, input_used,
//                halted, stack_overflow
// cfg_*    in   rows_used, written on any cycle with cfg_we high
//
// After reset the grid is cleared to spaces, one cell a cycle, over all ROWS*COLS
// cells (2000 by default); no beat is taken meanwhile.
// A load writes the grid in the cycle it is taken. A step does one grid read, ST_POP
// and ST_POP_WAIT per stack pop, ST_PUSH once per push; divide and modulo add ST_DIV
// and ST_DIV_FIX (bit-serial divider). Grid and stack ports are single read, single write.
// A new beat is taken only when idle and the result register is empty.

module stack_grid_interpreter_step_top #(
    parameter int ROWS        = sgi_pkg::ROWS_DEF,
    parameter int COLS        = sgi_pkg::COLS_DEF,
    parameter int STACK_DEPTH = sgi_pkg::STACK_DEPTH_DEF
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [55:0] s_tdata,   // cell_row, cell_col, cell_char, input_value
    input  wire logic [0:0]  s_tuser,   // command
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [39:0] m_tdata,   // out_valid, out_value, input_used, halted,
                                        // stack_overflow
    output logic      [0:0]  m_tuser,   // out_is_char
    input  wire logic        cfg_we,
    input  wire logic [4:0]  cfg_wdata  // rows_used
);

    localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int CW    = (COLS > 1) ? $clog2(COLS) : 1;
    localparam int ERW   = $clog2(ROWS + 1);
    localparam int GDEP  = ROWS * COLS;
    localparam int GAW   = (GDEP > 1) ? $clog2(GDEP) : 1;
    localparam int SW    = $clog2(STACK_DEPTH);
    localparam int DW    = sgi_pkg::DATA_W;

    sgi_pkg::state_t   state_reg, state_next;
    sgi_pkg::heading_t heading_reg, heading_next;

    logic [4:0]     rows_used_reg;
    logic [GAW-1:0] clr_reg, clr_next;
    logic [RW-1:0]  prow_reg, prow_next;
    logic [CW-1:0]  pcol_reg, pcol_next;
    logic [SW:0]    count_reg, count_next;
    logic           bridge_reg, bridge_next;
    logic           string_reg, string_next;
    logic           stopped_reg, stopped_next;
    logic           halt_now_reg, halt_now_next;
    logic           ov_reg, ov_next;
    logic           oc_reg, oc_next;
    logic [DW-1:0]  oval_reg, oval_next;
    logic           iu_reg, iu_next;
    logic           ovf_reg, ovf_next;
    logic           mvalid_reg, mvalid_next;
    logic [7:0]     c_reg, c_next;
    logic [DW-1:0]  in_reg, in_next;
    logic [DW-1:0]  x_reg, x_next, y_reg, y_next, z_reg, z_next;
    logic [DW-1:0]  pa_reg, pa_next, pb_reg, pb_next;
    logic [1:0]     npush_reg, npush_next;
    logic [1:0]     pops_reg, pops_next;
    logic [1:0]     pidx_reg, pidx_next;
    logic [DW-1:0]  dvd_reg, dvd_next, dsr_reg, dsr_next, rem_reg, rem_next;
    logic [4:0]     dcnt_reg, dcnt_next;

    logic           g_we;
    logic [GAW-1:0] g_waddr, g_raddr;
    logic [7:0]     g_wdata, g_rdata;
    logic           s_we;
    logic [SW-1:0]  s_waddr, s_raddr;
    logic [DW-1:0]  s_wdata, s_rdata;

    logic [4:0]     in_row;
    logic [6:0]     in_col;
    logic [7:0]     in_char;
    logic           in_cmd;
    logic           accept;
    logic [ERW-1:0] eff_rows;
    logic [GAW-1:0] ptr_addr, get_addr, load_addr;
    logic           xy_in_grid;
    logic           load_ok;
    logic [SW:0]    count_m1;
    logic [DW:0]    div_shift, div_diff;
    logic [DW-1:0]  pop_val;

    assign in_cmd  = s_tuser[0];
    assign in_row  = s_tdata[4:0];
    assign in_col  = s_tdata[11:5];
    assign in_char = s_tdata[19:12];

    assign s_tready = (state_reg == sgi_pkg::ST_IDLE) && !mvalid_reg;
    assign accept   = s_tvalid && s_tready;

    assign m_tvalid = mvalid_reg;
    assign m_tdata  = {4'b0, ovf_reg, stopped_reg, iu_reg, oval_reg, ov_reg};
    assign m_tuser  = oc_reg;

    always_comb
    begin
        if (rows_used_reg == 5'd0)
            eff_rows = ERW'(1);
        else if (32'(rows_used_reg) > ROWS)
            eff_rows = ERW'(ROWS);
        else
            eff_rows = ERW'(rows_used_reg);
    end

    assign ptr_addr   = GAW'(prow_reg) * GAW'(COLS) + GAW'(pcol_reg);
    assign get_addr   = GAW'(x_reg) * GAW'(COLS) + GAW'(y_reg);
    assign load_addr  = GAW'(in_row) * GAW'(COLS) + GAW'(in_col);
    assign xy_in_grid = (x_reg < 32'(eff_rows)) && (y_reg < 32'(COLS));
    assign load_ok    = (32'(in_row) < ROWS) && (32'(in_col) < COLS);
    assign count_m1   = count_reg - 1'b1;
    assign div_shift  = {rem_reg, dvd_reg[DW-1]};
    assign div_diff   = div_shift - {1'b0, dsr_reg};
    assign pop_val    = (state_reg == sgi_pkg::ST_POP_WAIT) ? s_rdata : '0;

    sgi_ram #(.WIDTH(8), .DEPTH(GDEP)) u_grid (
        .clk   (clk),
        .we    (g_we),
        .waddr (g_waddr),
        .wdata (g_wdata),
        .raddr (g_raddr),
        .rdata (g_rdata)
    );

    sgi_ram #(.WIDTH(DW), .DEPTH(STACK_DEPTH)) u_stack (
        .clk   (clk),
        .we    (s_we),
        .waddr (s_waddr),
        .wdata (s_wdata),
        .raddr (s_raddr),
        .rdata (s_rdata)
    );

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            sgi_pkg::ST_CLEAR:
            begin
                if (clr_reg == GAW'(GDEP - 1))
                    state_next = sgi_pkg::ST_IDLE;
            end
            sgi_pkg::ST_IDLE:
            begin
                if (accept && in_cmd == sgi_pkg::CMD_STEP && !stopped_reg)
                    state_next = sgi_pkg::ST_FETCH;
            end
            sgi_pkg::ST_FETCH:
            begin
                if (bridge_reg)
                    state_next = sgi_pkg::ST_MOVE;
                else if (string_reg)
                    state_next = (g_rdata == sgi_pkg::CH_QUOTE) ? sgi_pkg::ST_MOVE
                                                                : sgi_pkg::ST_PUSH;
                else if (sgi_pkg::pop_count(g_rdata) != 2'd0)
                    state_next = sgi_pkg::ST_POP;
                else
                    state_next = sgi_pkg::ST_EXEC;
            end
            sgi_pkg::ST_POP:
            begin
                if (count_reg != '0)
                    state_next = sgi_pkg::ST_POP_WAIT;
                else if (pops_reg == 2'd1)
                    state_next = sgi_pkg::ST_EXEC;
            end
            sgi_pkg::ST_POP_WAIT:
            begin
                state_next = (pops_reg == 2'd1) ? sgi_pkg::ST_EXEC : sgi_pkg::ST_POP;
            end
            sgi_pkg::ST_EXEC:
            begin
                case (c_reg)
                    sgi_pkg::CH_DIV, sgi_pkg::CH_MOD:
                        state_next = (x_reg == '0) ? sgi_pkg::ST_PUSH : sgi_pkg::ST_DIV;
                    sgi_pkg::CH_GET:
                        state_next = xy_in_grid ? sgi_pkg::ST_GET_WAIT : sgi_pkg::ST_PUSH;
                    sgi_pkg::CH_INNUM, sgi_pkg::CH_INCHR, sgi_pkg::CH_ADD,
                    sgi_pkg::CH_SUB, sgi_pkg::CH_MUL, sgi_pkg::CH_GREATER,
                    sgi_pkg::CH_NOT, sgi_pkg::CH_DUP, sgi_pkg::CH_SWAP:
                        state_next = sgi_pkg::ST_PUSH;
                    default:
                    begin
                        if (c_reg >= sgi_pkg::CH_ZERO && c_reg <= sgi_pkg::CH_NINE)
                            state_next = sgi_pkg::ST_PUSH;
                        else
                            state_next = sgi_pkg::ST_MOVE;
                    end
                endcase
            end
            sgi_pkg::ST_DIV:
            begin
                if (dcnt_reg == 5'd31)
                    state_next = sgi_pkg::ST_DIV_FIX;
            end
            sgi_pkg::ST_DIV_FIX:  state_next = sgi_pkg::ST_PUSH;
            sgi_pkg::ST_GET_WAIT: state_next = sgi_pkg::ST_PUSH;
            sgi_pkg::ST_PUSH:
            begin
                if (npush_reg <= 2'd1)
                    state_next = sgi_pkg::ST_MOVE;
            end
            sgi_pkg::ST_MOVE:     state_next = sgi_pkg::ST_IDLE;
            default:              state_next = sgi_pkg::ST_CLEAR;
        endcase
    end

    // Datapath and memory controls.
    always_comb
    begin
        logic [DW-1:0] q_mag;
        logic [DW-1:0] r_mag;

        clr_next      = clr_reg;
        prow_next     = prow_reg;
        pcol_next     = pcol_reg;
        heading_next  = heading_reg;
        count_next    = count_reg;
        bridge_next   = bridge_reg;
        string_next   = string_reg;
        stopped_next  = stopped_reg;
        halt_now_next = halt_now_reg;
        ov_next       = ov_reg;
        oc_next       = oc_reg;
        oval_next     = oval_reg;
        iu_next       = iu_reg;
        ovf_next      = ovf_reg;
        mvalid_next   = mvalid_reg && !m_tready;
        c_next        = c_reg;
        in_next       = in_reg;
        x_next        = x_reg;
        y_next        = y_reg;
        z_next        = z_reg;
        pa_next       = pa_reg;
        pb_next       = pb_reg;
        npush_next    = npush_reg;
        pops_next     = pops_reg;
        pidx_next     = pidx_reg;
        dvd_next      = dvd_reg;
        dsr_next      = dsr_reg;
        rem_next      = rem_reg;
        dcnt_next     = dcnt_reg;
        q_mag         = dvd_reg;
        r_mag         = rem_reg;

        g_we    = 1'b0;
        g_waddr = load_addr;
        g_wdata = in_char;
        g_raddr = ptr_addr;
        s_we    = 1'b0;
        s_waddr = count_reg[SW-1:0];
        s_wdata = pa_reg;
        s_raddr = count_m1[SW-1:0];

        case (state_reg)
            sgi_pkg::ST_CLEAR:
            begin
                g_we    = 1'b1;
                g_waddr = clr_reg;
                g_wdata = sgi_pkg::CH_SPACE;
                clr_next = clr_reg + 1'b1;
            end
            sgi_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    ov_next       = 1'b0;
                    oc_next       = 1'b0;
                    oval_next     = '0;
                    iu_next       = 1'b0;
                    ovf_next      = 1'b0;
                    halt_now_next = 1'b0;
                    npush_next    = 2'd0;
                    in_next       = s_tdata[51:20];
                    if (in_cmd == sgi_pkg::CMD_LOAD)
                    begin
                        g_we        = load_ok;
                        mvalid_next = 1'b1;
                    end
                    else if (stopped_reg)
                    begin
                        mvalid_next = 1'b1;
                    end
                end
            end
            sgi_pkg::ST_FETCH:
            begin
                c_next    = g_rdata;
                pidx_next = 2'd0;
                pops_next = sgi_pkg::pop_count(g_rdata);
                if (bridge_reg)
                    bridge_next = 1'b0;
                else if (string_reg)
                begin
                    if (g_rdata == sgi_pkg::CH_QUOTE)
                        string_next = 1'b0;
                    else
                    begin
                        pa_next    = DW'(g_rdata);
                        npush_next = 2'd1;
                    end
                end
            end
            sgi_pkg::ST_POP, sgi_pkg::ST_POP_WAIT:
            begin
                if (state_reg == sgi_pkg::ST_POP && count_reg != '0)
                    count_next = count_m1;
                else
                begin
                    case (pidx_reg)
                        2'd0:    x_next = pop_val;
                        2'd1:    y_next = pop_val;
                        default: z_next = pop_val;
                    endcase
                    pidx_next = pidx_reg + 1'b1;
                    pops_next = pops_reg - 1'b1;
                end
            end
            sgi_pkg::ST_EXEC:
            begin
                npush_next = 2'd1;
                case (c_reg)
                    sgi_pkg::CH_RIGHT: heading_next = sgi_pkg::HEAD_RIGHT;
                    sgi_pkg::CH_LEFT:  heading_next = sgi_pkg::HEAD_LEFT;
                    sgi_pkg::CH_DOWN:  heading_next = sgi_pkg::HEAD_DOWN;
                    sgi_pkg::CH_UP:    heading_next = sgi_pkg::HEAD_UP;
                    sgi_pkg::CH_HBRANCH:
                        heading_next = (x_reg == '0) ? sgi_pkg::HEAD_RIGHT
                                                     : sgi_pkg::HEAD_LEFT;
                    sgi_pkg::CH_VBRANCH:
                        heading_next = (x_reg == '0) ? sgi_pkg::HEAD_DOWN
                                                     : sgi_pkg::HEAD_UP;
                    sgi_pkg::CH_BRIDGE: bridge_next = 1'b1;
                    sgi_pkg::CH_QUOTE:  string_next = 1'b1;
                    sgi_pkg::CH_HALT:
                    begin
                        stopped_next  = 1'b1;
                        halt_now_next = 1'b1;
                    end
                    sgi_pkg::CH_INNUM, sgi_pkg::CH_INCHR:
                    begin
                        pa_next = in_reg;
                        iu_next = 1'b1;
                    end
                    sgi_pkg::CH_OUTNUM, sgi_pkg::CH_OUTCHR:
                    begin
                        ov_next   = 1'b1;
                        oc_next   = (c_reg == sgi_pkg::CH_OUTCHR);
                        oval_next = x_reg;
                    end
                    sgi_pkg::CH_ADD:     pa_next = y_reg + x_reg;
                    sgi_pkg::CH_SUB:     pa_next = y_reg - x_reg;
                    sgi_pkg::CH_MUL:     pa_next = y_reg * x_reg;
                    sgi_pkg::CH_DIV, sgi_pkg::CH_MOD:
                    begin
                        // Unsigned restoring division on magnitudes; signs fixed after.
                        pa_next   = '0;
                        dvd_next  = y_reg[DW-1] ? (DW'(0) - y_reg) : y_reg;
                        dsr_next  = x_reg[DW-1] ? (DW'(0) - x_reg) : x_reg;
                        rem_next  = '0;
                        dcnt_next = 5'd0;
                    end
                    sgi_pkg::CH_GREATER:
                        pa_next = DW'($signed(y_reg) > $signed(x_reg));
                    sgi_pkg::CH_NOT:     pa_next = DW'(x_reg == '0);
                    sgi_pkg::CH_DUP:
                    begin
                        pa_next    = x_reg;
                        pb_next    = x_reg;
                        npush_next = 2'd2;
                    end
                    sgi_pkg::CH_SWAP:
                    begin
                        pa_next    = x_reg;
                        pb_next    = y_reg;
                        npush_next = 2'd2;
                    end
                    sgi_pkg::CH_GET:
                    begin
                        pa_next = '0;
                        g_raddr = get_addr;
                    end
                    sgi_pkg::CH_PUT:
                    begin
                        g_we    = xy_in_grid;
                        g_waddr = get_addr;
                        g_wdata = z_reg[7:0];
                    end
                    default:
                    begin
                        pa_next = DW'(c_reg - sgi_pkg::CH_ZERO);
                    end
                endcase
            end
            sgi_pkg::ST_DIV:
            begin
                if (!div_diff[DW])
                    rem_next = div_diff[DW-1:0];
                else
                    rem_next = div_shift[DW-1:0];
                dvd_next  = {dvd_reg[DW-2:0], !div_diff[DW]};
                dcnt_next = dcnt_reg + 1'b1;
            end
            sgi_pkg::ST_DIV_FIX:
            begin
                if (c_reg == sgi_pkg::CH_MOD)
                    pa_next = y_reg[DW-1] ? (DW'(0) - r_mag) : r_mag;
                else
                    pa_next = (y_reg[DW-1] ^ x_reg[DW-1]) ? (DW'(0) - q_mag) : q_mag;
            end
            sgi_pkg::ST_GET_WAIT:
            begin
                pa_next = DW'(g_rdata);
            end
            sgi_pkg::ST_PUSH:
            begin
                if (npush_reg != 2'd0)
                begin
                    if (32'(count_reg) >= STACK_DEPTH)
                        ovf_next = 1'b1;
                    else
                    begin
                        s_we       = 1'b1;
                        count_next = count_reg + 1'b1;
                    end
                    pa_next    = pb_reg;
                    npush_next = npush_reg - 1'b1;
                end
            end
            sgi_pkg::ST_MOVE:
            begin
                mvalid_next = 1'b1;
                if (!halt_now_reg)
                begin
                    case (heading_reg)
                        sgi_pkg::HEAD_RIGHT:
                            pcol_next = (32'(pcol_reg) + 1 >= COLS) ? '0 : pcol_reg + 1'b1;
                        sgi_pkg::HEAD_LEFT:
                            pcol_next = (pcol_reg == '0) ? CW'(COLS - 1) : pcol_reg - 1'b1;
                        sgi_pkg::HEAD_DOWN:
                            prow_next = (32'(prow_reg) + 1 >= 32'(eff_rows)) ? '0
                                                                          : prow_reg + 1'b1;
                        default:
                        begin
                            // A pointer left below a shrunken row range wraps upward
                            // to the last used row.
                            if (prow_reg == '0 || 32'(prow_reg) > 32'(eff_rows))
                                prow_next = RW'(eff_rows - 1'b1);
                            else
                                prow_next = prow_reg - 1'b1;
                        end
                    endcase
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sgi_pkg::ST_CLEAR;
            heading_reg   <= sgi_pkg::HEAD_RIGHT;
            rows_used_reg <= 5'(ROWS);
            clr_reg       <= '0;
            prow_reg      <= '0;
            pcol_reg      <= '0;
            count_reg     <= '0;
            bridge_reg    <= 1'b0;
            string_reg    <= 1'b0;
            stopped_reg   <= 1'b0;
            halt_now_reg  <= 1'b0;
            mvalid_reg    <= 1'b0;
            npush_reg     <= 2'd0;
            pops_reg      <= 2'd0;
            pidx_reg      <= 2'd0;
            dcnt_reg      <= 5'd0;
        end
        else
        begin
            state_reg     <= state_next;
            heading_reg   <= heading_next;
            if (cfg_we)
                rows_used_reg <= cfg_wdata;
            clr_reg       <= clr_next;
            prow_reg      <= prow_next;
            pcol_reg      <= pcol_next;
            count_reg     <= count_next;
            bridge_reg    <= bridge_next;
            string_reg    <= string_next;
            stopped_reg   <= stopped_next;
            halt_now_reg  <= halt_now_next;
            mvalid_reg    <= mvalid_next;
            npush_reg     <= npush_next;
            pops_reg      <= pops_next;
            pidx_reg      <= pidx_next;
            dcnt_reg      <= dcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ov_reg   <= ov_next;
        oc_reg   <= oc_next;
        oval_reg <= oval_next;
        iu_reg   <= iu_next;
        ovf_reg  <= ovf_next;
        c_reg    <= c_next;
        in_reg   <= in_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        pa_reg   <= pa_next;
        pb_reg   <= pb_next;
        dvd_reg  <= dvd_next;
        dsr_reg  <= dsr_next;
        rem_reg  <= rem_next;
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        32'(count_reg) <= STACK_DEPTH)
        else $error("stack count beyond depth");

    a_halt_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        stopped_reg |=> stopped_reg)
        else $error("halt state cleared without reset");

    a_col_range: assert property (@(posedge clk) disable iff (!rst_n)
        32'(pcol_reg) < COLS)
        else $error("pointer column out of range");

    a_no_take_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != sgi_pkg::ST_IDLE) |-> !s_tready)
        else $error("input taken while a step is running");
`endif

endmodule

`default_nettype wire
